// ===== hdl/adaptive_hybrid_cache_replacement_defines.svh =====
// ----------------------------------------------------------------------------
// Adaptive hybrid cache replacement assertion macros
// Concurrent check helpers used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_HYBRID_CACHE_REPLACEMENT_DEFINES_SVH
`define ADAPTIVE_HYBRID_CACHE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTH
`define AHCR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AHCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AHCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define AHCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/ahcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive hybrid cache replacement package
// Sizes, register codes, memory row layouts and shared helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ahcr_pkg;

	localparam int NUM_SETS   = 2048;
	localparam int NUM_WAYS   = 16;
	localparam int WINDOW_LEN = 16;

	localparam int SET_W   = $clog2(NUM_SETS);
	localparam int WAY_W   = $clog2(NUM_WAYS);
	localparam int WPTR_W  = $clog2(WINDOW_LEN);
	localparam int HITS_W  = $clog2(WINDOW_LEN + 1);
	localparam int LEAVES  = 1 << WAY_W;

	localparam int FUNC_W  = 1;
	localparam int SIDX_W  = 11;
	localparam int MASK_W  = 16;
	localparam int WIN_W   = 4;
	localparam int ADDR_W  = 64;
	localparam int AGE_W   = 8;
	localparam int RRPV_W  = 2;
	localparam int RC_W    = 8;
	localparam int LFSR_W  = 16;

	localparam int PADDR_W    = 4;
	localparam int APB_DATA_W = 32;
	localparam int LRU_THR_W  = 5;
	localparam int SRRIP_THR_W = 5;
	localparam int RND_THR_W  = 8;
	localparam int STRIDE_W   = 16;

	localparam logic [1:0] REG_LRU_THR    = 2'd0;
	localparam logic [1:0] REG_SRRIP_THR  = 2'd1;
	localparam logic [1:0] REG_RND_THR    = 2'd2;
	localparam logic [1:0] REG_STRIDE_LIM = 2'd3;

	localparam logic [LRU_THR_W-1:0]   LRU_THR_RST    = 5'd8;
	localparam logic [SRRIP_THR_W-1:0] SRRIP_THR_RST  = 5'd3;
	localparam logic [RND_THR_W-1:0]   RND_THR_RST    = 8'd6;
	localparam logic [STRIDE_W-1:0]    STRIDE_LIM_RST = 16'd4096;

	localparam logic [FUNC_W-1:0] FUNC_VICTIM = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b1;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

	localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;
	localparam logic [RRPV_W-1:0] RRPV_LONG    = 2'd2;
	localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;
	localparam logic [AGE_W-1:0]  AGE_MAX      = 8'hFF;
	localparam logic [AGE_W-1:0]  AGE_INSERT   = AGE_W'(NUM_WAYS - 1);
	localparam logic [RC_W-1:0]   RC_MAX       = 8'hFF;

	typedef struct packed {
		logic ptr;
		logic srrip;
		logic lru;
	} flags_t;

	typedef struct packed {
		logic [WINDOW_LEN-1:0] hit_window;
		logic [WPTR_W-1:0]     wptr;
		flags_t                flags;
		logic [ADDR_W-1:0]     prev_addr;
		logic [RC_W-1:0]       rcount;
	} set_row_t;

	typedef struct packed {
		logic [NUM_WAYS-1:0][AGE_W-1:0]  age;
		logic [NUM_WAYS-1:0][RRPV_W-1:0] rrpv;
	} way_row_t;

	typedef struct packed {
		logic [WINDOW_LEN-1:0] hit_window;
		logic [WPTR_W-1:0]     wptr;
		logic [HITS_W-1:0]     hits;
		logic                  prev_nz;
		logic [ADDR_W-1:0]     stride;
	} upd_ctx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	localparam set_row_t SET_ROW_RST = '0;

	function automatic way_row_t way_row_rst();
		way_row_t r;
		for (int i = 0; i < NUM_WAYS; i++) begin
			r.age[i]  = '0;
			r.rrpv[i] = RRPV_DISTANT;
		end
		return r;
	endfunction

	function automatic logic [WAY_W-1:0] first_set(input logic [NUM_WAYS-1:0] v);
		logic [WAY_W-1:0] r;
		r = '0;
		for (int i = NUM_WAYS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = WAY_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/ahcr_if.sv =====
// ----------------------------------------------------------------------------
// Adaptive hybrid cache replacement channels
// Request and response handshake interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ahcr_req_if;
	import ahcr_pkg::*;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [SIDX_W-1:0]   set_index;
	logic [MASK_W-1:0]   valid_mask;
	logic [WIN_W-1:0]    way;
	logic [ADDR_W-1:0]   paddr;
	logic                hit;

	modport source (output valid, func, set_index, valid_mask, way, paddr, hit, input ready);
	modport sink (input valid, func, set_index, valid_mask, way, paddr, hit, output ready);
endinterface

interface ahcr_rsp_if;
	import ahcr_pkg::*;
	logic              valid;
	logic              ready;
	logic [WIN_W-1:0]  victim_way;

	modport source (output valid, victim_way, input ready);
	modport sink (input valid, victim_way, output ready);
endinterface

// ===== hdl/ahcr_ram.sv =====
// ----------------------------------------------------------------------------
// Adaptive hybrid cache replacement RAM
// Simple dual-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ahcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ahcr_victim.sv =====
// ----------------------------------------------------------------------------
// Adaptive hybrid cache replacement victim selection
// Picks the eviction way for the set's mode and ages the RRPVs when needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ahcr_victim (
	input  ahcr_pkg::flags_t                    flags,
	input  logic [ahcr_pkg::MASK_W-1:0]         valid_mask,
	input  ahcr_pkg::way_row_t                  row,
	input  logic [ahcr_pkg::LFSR_W-1:0]         lfsr_next,
	output logic [ahcr_pkg::WAY_W-1:0]          victim,
	output ahcr_pkg::way_row_t                  aged_row,
	output logic                                aged_we,
	output logic                                lfsr_step
);
	import ahcr_pkg::*;

	logic [NUM_WAYS-1:0] inv;
	logic [NUM_WAYS-1:0] eq3;
	logic [NUM_WAYS-1:0] eq2;
	logic [NUM_WAYS-1:0] eq1;
	logic [NUM_WAYS-1:0] eqm;
	logic [NUM_WAYS-1:0] pass0;
	logic                any_inv;
	logic [RRPV_W-1:0]   rmax;
	logic [RRPV_W-1:0]   boost;
	logic [WAY_W-1:0]    rrip_way;
	logic [LEAVES-1:0][AGE_W-1:0] tv [WAY_W+1];
	logic [LEAVES-1:0][WAY_W-1:0] ti [WAY_W+1];
	logic [LEAVES-1:0]            tp [WAY_W+1];

	always_comb begin
		for (int i = 0; i < NUM_WAYS; i++) begin
			inv[i] = (i < MASK_W) ? ~valid_mask[i] : 1'b0;
			eq3[i] = row.rrpv[i] == 2'd3;
			eq2[i] = row.rrpv[i] == 2'd2;
			eq1[i] = row.rrpv[i] == 2'd1;
		end
		any_inv = |inv;
		pass0   = inv | eq3;
		if (|eq3) begin
			rmax = 2'd3;
		end else if (|eq2) begin
			rmax = 2'd2;
		end else if (|eq1) begin
			rmax = 2'd1;
		end else begin
			rmax = 2'd0;
		end
		boost = RRPV_DISTANT - rmax;
		for (int i = 0; i < NUM_WAYS; i++) begin
			eqm[i] = row.rrpv[i] == rmax;
		end
		rrip_way = (|pass0) ? first_set(pass0) : first_set(eqm);
		aged_row = row;
		for (int i = 0; i < NUM_WAYS; i++) begin
			aged_row.rrpv[i] = row.rrpv[i] + boost;
		end
	end

	always_comb begin
		for (int j = 0; j < LEAVES; j++) begin
			tp[0][j] = j < NUM_WAYS;
			tv[0][j] = (j < NUM_WAYS) ? row.age[j % NUM_WAYS] : '0;
			ti[0][j] = WAY_W'(j);
		end
		for (int l = 1; l <= WAY_W; l++) begin
			tp[l] = '0;
			tv[l] = '0;
			ti[l] = '0;
			for (int j = 0; j < (LEAVES >> l); j++) begin
				if (tp[l-1][2*j+1] && (!tp[l-1][2*j] || tv[l-1][2*j+1] >= tv[l-1][2*j])) begin
					tp[l][j] = 1'b1;
					tv[l][j] = tv[l-1][2*j+1];
					ti[l][j] = ti[l-1][2*j+1];
				end else begin
					tp[l][j] = tp[l-1][2*j];
					tv[l][j] = tv[l-1][2*j];
					ti[l][j] = ti[l-1][2*j];
				end
			end
		end
	end

	always_comb begin
		aged_we   = 1'b0;
		lfsr_step = 1'b0;
		if (flags.ptr) begin
			lfsr_step = !any_inv;
			victim    = any_inv ? first_set(inv) : lfsr_next[WAY_W-1:0];
		end else if (flags.lru) begin
			victim = any_inv ? first_set(inv) : ti[WAY_W][0];
		end else begin
			victim  = rrip_way;
			aged_we = !(|pass0);
		end
	end

endmodule

// ===== hdl/ahcr_update.sv =====
// ----------------------------------------------------------------------------
// Adaptive hybrid cache replacement update logic
// Stride tracking, mode selection and promotion or insertion of one way.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ahcr_update (
	input  ahcr_pkg::upd_ctx_t                  ctx,
	input  ahcr_pkg::set_row_t                  set_old,
	input  ahcr_pkg::way_row_t                  way_old,
	input  logic [ahcr_pkg::WIN_W-1:0]          way,
	input  logic [ahcr_pkg::ADDR_W-1:0]         paddr,
	input  logic                                hit,
	input  logic [ahcr_pkg::LRU_THR_W-1:0]      lru_thr,
	input  logic [ahcr_pkg::SRRIP_THR_W-1:0]    srrip_thr,
	input  logic [ahcr_pkg::RND_THR_W-1:0]      rnd_thr,
	input  logic [ahcr_pkg::STRIDE_W-1:0]       stride_lim,
	output ahcr_pkg::set_row_t                  set_new,
	output ahcr_pkg::way_row_t                  way_new
);
	import ahcr_pkg::*;

	logic [ADDR_W-1:0] mag;
	logic              is_rand;
	logic [RC_W-1:0]   rc;
	flags_t            fl;
	logic [AGE_W-1:0]  old_age;
	logic [WAY_W-1:0]  w;
	logic              w_ok;

	always_comb begin
		mag     = ctx.stride[ADDR_W-1] ? (~ctx.stride + ADDR_W'(1)) : ctx.stride;
		is_rand = (ctx.stride == '0) || (mag > ADDR_W'(stride_lim));
		rc      = set_old.rcount;
		if (ctx.prev_nz) begin
			if (is_rand) begin
				if (rc != RC_MAX) begin
					rc = rc + RC_W'(1);
				end
			end else if (rc != '0) begin
				rc = rc - RC_W'(1);
			end
		end
		fl.lru   = ctx.hits > HITS_W'(lru_thr);
		fl.srrip = !fl.lru && (ctx.hits > HITS_W'(srrip_thr));
		fl.ptr   = ctx.prev_nz && (rc >= rnd_thr);

		set_new.hit_window = ctx.hit_window;
		set_new.wptr       = ctx.wptr;
		set_new.flags      = fl;
		set_new.prev_addr  = paddr;
		set_new.rcount     = rc;
	end

	always_comb begin
		w       = way[WAY_W-1:0];
		w_ok    = {1'b0, way} < (WIN_W + 1)'(NUM_WAYS);
		old_age = way_old.age[w];
		way_new = way_old;
		if (w_ok) begin
			if (hit) begin
				for (int i = 0; i < NUM_WAYS; i++) begin
					if (way_old.age[i] < old_age) begin
						way_new.age[i] = way_old.age[i] + AGE_W'(1);
					end
				end
				way_new.age[w]  = '0;
				way_new.rrpv[w] = RRPV_NEAR;
			end else if (fl.ptr) begin
				way_new.rrpv[w] = RRPV_DISTANT;
				way_new.age[w]  = AGE_INSERT;
			end else if (fl.lru) begin
				for (int i = 0; i < NUM_WAYS; i++) begin
					if (way_old.age[i] != AGE_MAX) begin
						way_new.age[i] = way_old.age[i] + AGE_W'(1);
					end
				end
				way_new.age[w]  = '0;
				way_new.rrpv[w] = RRPV_NEAR;
			end else if (fl.srrip) begin
				way_new.rrpv[w] = RRPV_LONG;
				way_new.age[w]  = AGE_INSERT;
			end else begin
				way_new.rrpv[w] = RRPV_DISTANT;
				way_new.age[w]  = AGE_INSERT;
			end
		end
	end

endmodule

// ===== hdl/adaptive_hybrid_cache_replacement.sv =====
// ----------------------------------------------------------------------------
// Adaptive hybrid cache replacement engine
// Per-set LRU / SRRIP / pointer-mode victim selection and state update.
//
// Channel  Dir  Handshake        Carries
// req      in   valid / ready    func, set_index, valid_mask, way, paddr, hit
// rsp      out  valid / ready    victim_way (victim requests only)
// apb      in   psel / penable   four threshold registers
//
// Each item goes through accept and memory read, window and stride subtract,
// then victim selection or update and write-back through two simple dual-port
// memories. After reset a clearing pass writes every set row; no item is
// accepted until it ends. A result waiting in the output register holds
// off intake until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adaptive_hybrid_cache_replacement_defines.svh"

module adaptive_hybrid_cache_replacement (
	input  logic                               clk,
	input  logic                               arst_n,
	ahcr_req_if.sink                           req,
	ahcr_rsp_if.source                         rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ahcr_pkg::PADDR_W-1:0]       paddr,
	input  logic [ahcr_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ahcr_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import ahcr_pkg::*;

	state_t state_q, state_d;

	logic [LRU_THR_W-1:0]   lru_thr_q;
	logic [SRRIP_THR_W-1:0] srrip_thr_q;
	logic [RND_THR_W-1:0]   rnd_thr_q;
	logic [STRIDE_W-1:0]    stride_lim_q;

	logic [SET_W-1:0]  clr_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] lfsr_next;

	logic [FUNC_W-1:0] func_q;
	logic [SET_W-1:0]  set_q;
	logic [MASK_W-1:0] mask_q;
	logic [WIN_W-1:0]  way_q;
	logic [ADDR_W-1:0] addr_q;
	logic              hit_q;

	logic             rsp_valid_q;
	logic [WIN_W-1:0] victim_q;

	upd_ctx_t ctx_d, ctx_s1;

	logic              accept;
	logic              rd_en;
	logic              set_we;
	logic              way_we;
	logic [SET_W-1:0]  waddr;
	set_row_t          set_wdata;
	way_row_t          way_wdata;
	logic [$bits(set_row_t)-1:0] set_rdata;
	logic [$bits(way_row_t)-1:0] way_rdata;
	set_row_t          set_rd;
	way_row_t          way_rd;

	set_row_t          set_upd;
	way_row_t          way_upd;
	way_row_t          way_aged;
	logic              aged_we;
	logic              lfsr_step;
	logic [WAY_W-1:0]  victim;

	assign pready = 1'b1;
	assign set_rd = set_row_t'(set_rdata);
	assign way_rd = way_row_t'(way_rdata);
	assign accept = req.valid && req.ready;
	assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lru_thr_q    <= LRU_THR_RST;
			srrip_thr_q  <= SRRIP_THR_RST;
			rnd_thr_q    <= RND_THR_RST;
			stride_lim_q <= STRIDE_LIM_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_LRU_THR:    lru_thr_q    <= pwdata[LRU_THR_W-1:0];
				REG_SRRIP_THR:  srrip_thr_q  <= pwdata[SRRIP_THR_W-1:0];
				REG_RND_THR:    rnd_thr_q    <= pwdata[RND_THR_W-1:0];
				REG_STRIDE_LIM: stride_lim_q <= pwdata[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LRU_THR:    prdata = APB_DATA_W'(lru_thr_q);
			REG_SRRIP_THR:  prdata = APB_DATA_W'(srrip_thr_q);
			REG_RND_THR:    prdata = APB_DATA_W'(rnd_thr_q);
			REG_STRIDE_LIM: prdata = APB_DATA_W'(stride_lim_q);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == SET_W'(NUM_SETS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_READ;
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
		rd_en     = accept;
		set_we    = 1'b0;
		way_we    = 1'b0;
		waddr     = set_q;
		set_wdata = set_upd;
		way_wdata = way_upd;
		unique case (state_q)
			ST_CLEAR: begin
				set_we    = 1'b1;
				way_we    = 1'b1;
				waddr     = clr_q;
				set_wdata = SET_ROW_RST;
				way_wdata = way_row_rst();
			end
			ST_EXEC: begin
				if (func_q == FUNC_UPDATE) begin
					set_we = 1'b1;
					way_we = 1'b1;
				end else begin
					way_we    = aged_we;
					way_wdata = way_aged;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			lfsr_q      <= LFSR_SEED;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (state_q == ST_EXEC && func_q == FUNC_VICTIM) begin
				rsp_valid_q <= 1'b1;
				if (lfsr_step) begin
					lfsr_q <= lfsr_next;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			set_q  <= req.set_index[SET_W-1:0];
			mask_q <= req.valid_mask;
			way_q  <= req.way;
			addr_q <= req.paddr;
			hit_q  <= req.hit;
		end
		if (state_q == ST_READ) begin
			ctx_s1 <= ctx_d;
		end
		if (state_q == ST_EXEC && func_q == FUNC_VICTIM) begin
			victim_q <= WIN_W'(victim);
		end
	end

	always_comb begin
		logic [WPTR_W-1:0] p;
		p = (set_rd.wptr >= WPTR_W'(WINDOW_LEN - 1) + WPTR_W'(1) && WINDOW_LEN != (1 << WPTR_W))
			? '0 : set_rd.wptr;
		ctx_d.hit_window    = set_rd.hit_window;
		ctx_d.hit_window[p] = hit_q;
		ctx_d.wptr          = (p == WPTR_W'(WINDOW_LEN - 1)) ? '0 : p + WPTR_W'(1);
		ctx_d.hits          = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			ctx_d.hits = ctx_d.hits + HITS_W'(ctx_d.hit_window[i]);
		end
		ctx_d.prev_nz = |set_rd.prev_addr;
		ctx_d.stride  = addr_q - set_rd.prev_addr;
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.victim_way = victim_q;

	ahcr_ram #(
		.WIDTH($bits(set_row_t)),
		.DEPTH(NUM_SETS)
	) u_set_ram (
		.clk  (clk),
		.we   (set_we),
		.waddr(waddr),
		.wdata(set_wdata),
		.re   (rd_en),
		.raddr(req.set_index[SET_W-1:0]),
		.rdata(set_rdata)
	);

	ahcr_ram #(
		.WIDTH($bits(way_row_t)),
		.DEPTH(NUM_SETS)
	) u_way_ram (
		.clk  (clk),
		.we   (way_we),
		.waddr(waddr),
		.wdata(way_wdata),
		.re   (rd_en),
		.raddr(req.set_index[SET_W-1:0]),
		.rdata(way_rdata)
	);

	ahcr_victim u_victim (
		.flags     (set_rd.flags),
		.valid_mask(mask_q),
		.row       (way_rd),
		.lfsr_next (lfsr_next),
		.victim    (victim),
		.aged_row  (way_aged),
		.aged_we   (aged_we),
		.lfsr_step (lfsr_step)
	);

	ahcr_update u_update (
		.ctx       (ctx_s1),
		.set_old   (set_rd),
		.way_old   (way_rd),
		.way       (way_q),
		.paddr     (addr_q),
		.hit       (hit_q),
		.lru_thr   (lru_thr_q),
		.srrip_thr (srrip_thr_q),
		.rnd_thr   (rnd_thr_q),
		.stride_lim(stride_lim_q),
		.set_new   (set_upd),
		.way_new   (way_upd)
	);

	`AHCR_ASSERT(a_rsp_from_exec, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == ST_EXEC), "response raised outside execute")
	`AHCR_ASSERT(a_exec_after_read, clk, arst_n, state_q == ST_EXEC |-> $past(state_q == ST_READ), "execute not preceded by read")
	`AHCR_ASSERT(a_no_write_idle, clk, arst_n, state_q == ST_IDLE |-> !set_we && !way_we, "memory written while idle")
	`AHCR_ASSERT(a_lfsr_nonzero, clk, arst_n, lfsr_q != '0, "random generator reached zero")

endmodule
